/* hdl/cfa_pkg.sv */
// ----------------------------------------------------------------------------
// cfa_pkg: shared types and codes of the contiguous fit allocator
// Beat layouts of the request and result channels, opcodes, status codes
// and placement policy codes.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int RUN_LEN_W   = 11;
    localparam int OWNER_ID_W  = 16;
    localparam int START_IDX_W = 10;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    // Placement policies; any other code acts as first fit
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;
    localparam logic [1:0] FIT_POLICY_RST = POL_BEST;

    typedef struct packed {
        logic                  opcode;
        logic [OWNER_ID_W-1:0] owner_id;
        logic [RUN_LEN_W-1:0]  run_length;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [START_IDX_W-1:0] start_index;
    } out_beat_t;

endpackage

/* hdl/cfa_map_ram.sv */
// ----------------------------------------------------------------------------
// cfa_map_ram: owner map storage
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cfa_map_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/cfa_engine.sv */
// ----------------------------------------------------------------------------
// cfa_engine: scan, fill and clear sequencer around the owner map
// Sweeps the map after reset, scans it for free runs, writes the chosen run
// and frees cells of an owner by read-compare-write.
// ----------------------------------------------------------------------------
module cfa_engine
    import cfa_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int OWNER_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] fit_policy,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_beat_t   in_beat,
    output logic       res_valid,
    input  logic       res_ready,
    output out_beat_t  res_beat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > RUN_LEN_W) ? CW : RUN_LEN_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_WAIT, S_DECIDE, S_FILL, S_CSCAN, S_CWAIT, S_RESULT
    } state_t;

    state_t                state_reg;
    logic [CW-1:0]         cnt_reg;
    logic                  proc_valid_reg;
    logic [CW-1:0]         proc_idx_reg;
    logic                  op_reg;
    logic [OWNER_BITS-1:0] owner_reg;
    logic [LW-1:0]         len_reg;
    logic [1:0]            policy_reg;
    logic [AW-1:0]         run_start_reg;
    logic [CW-1:0]         run_len_reg;
    logic [AW-1:0]         best_start_reg;
    logic [CW-1:0]         best_len_reg;
    logic                  found_reg;
    logic [AW-1:0]         fill_addr_reg;
    logic [CW-1:0]         fill_left_reg;
    out_beat_t             res_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [OWNER_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [OWNER_BITS-1:0] mem_rdata;

    logic [OWNER_BITS-1:0] in_owner;
    logic [LW-1:0]         in_len;
    logic                  is_free;
    logic                  fits;
    logic                  take;
    logic                  clr_hit;

    cfa_map_ram #(
        .DEPTH (DEPTH),
        .WIDTH (OWNER_BITS)
    ) u_map (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (mem_rdata)
    );

    assign in_owner  = OWNER_BITS'(in_beat.owner_id);
    assign in_len    = LW'(in_beat.run_length);
    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESULT);
    assign res_beat  = res_reg;

    // Run tracking on the cell returned by the previous read; index DEPTH
    // is the end marker and always counts as taken.
    assign is_free = (proc_idx_reg != CW'(DEPTH)) && (mem_rdata == '0);
    assign fits    = LW'(run_len_reg) >= len_reg;
    assign clr_hit = proc_valid_reg && (op_reg == OP_CLEAR) && (mem_rdata == owner_reg);

    always_comb begin
        case (policy_reg)
            POL_BEST:  take = !found_reg || (run_len_reg < best_len_reg);
            POL_WORST: take = !found_reg || (run_len_reg > best_len_reg);
            default:   take = !found_reg;
        endcase
    end

    // Map port control. Reads always lead writes to the same cell, so the
    // write-back of a clear never meets a pending read of that cell.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cnt_reg[AW-1:0];
        mem_wdata = '0;
        mem_re    = 1'b0;
        case (state_reg)
            S_INIT:  mem_we = 1'b1;
            S_SCAN:  mem_re = (cnt_reg != CW'(DEPTH));
            S_CSCAN: mem_re = 1'b1;
            S_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                mem_wdata = owner_reg;
            end
            default: mem_re = 1'b0;
        endcase
        if (clr_hit) begin
            mem_we    = 1'b1;
            mem_waddr = proc_idx_reg[AW-1:0];
            mem_wdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            cnt_reg        <= '0;
            proc_valid_reg <= 1'b0;
            found_reg      <= 1'b0;
            run_len_reg    <= '0;
        end else begin
            proc_valid_reg <= (state_reg == S_SCAN) || (state_reg == S_CSCAN);
            proc_idx_reg   <= cnt_reg;

            if (proc_valid_reg && (op_reg == OP_ALLOC)) begin
                if (is_free) begin
                    if (run_len_reg == '0) begin
                        run_start_reg <= proc_idx_reg[AW-1:0];
                    end
                    run_len_reg <= run_len_reg + 1'b1;
                end else begin
                    if (fits && take) begin
                        best_start_reg <= run_start_reg;
                        best_len_reg   <= run_len_reg;
                        found_reg      <= 1'b1;
                    end
                    run_len_reg <= '0;
                end
            end

            case (state_reg)
                S_INIT: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DEPTH - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_valid) begin
                        op_reg      <= in_beat.opcode;
                        owner_reg   <= in_owner;
                        len_reg     <= in_len;
                        policy_reg  <= fit_policy;
                        cnt_reg     <= '0;
                        run_len_reg <= '0;
                        found_reg   <= 1'b0;
                        res_reg     <= '0;
                        if (in_beat.opcode == OP_CLEAR) begin
                            res_reg.status <= ST_CLEAR;
                            state_reg      <= (in_owner == '0) ? S_RESULT : S_CSCAN;
                        end else if ((in_owner == '0) || (in_len == '0) ||
                                     (in_len > LW'(DEPTH))) begin
                            res_reg.status <= ST_NOFIT;
                            state_reg      <= S_RESULT;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DEPTH)) begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT: state_reg <= S_DECIDE;
                S_DECIDE: begin
                    if (found_reg) begin
                        fill_addr_reg       <= best_start_reg;
                        fill_left_reg       <= CW'(len_reg);
                        res_reg.status      <= ST_ALLOC;
                        res_reg.start_index <= START_IDX_W'(best_start_reg);
                        state_reg           <= S_FILL;
                    end else begin
                        res_reg.status <= ST_NOFIT;
                        state_reg      <= S_RESULT;
                    end
                end
                S_FILL: begin
                    fill_addr_reg <= fill_addr_reg + 1'b1;
                    fill_left_reg <= fill_left_reg - 1'b1;
                    if (fill_left_reg == CW'(1)) begin
                        state_reg <= S_RESULT;
                    end
                end
                S_CSCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CW'(DEPTH - 1)) begin
                        state_reg <= S_CWAIT;
                    end
                end
                S_CWAIT: state_reg <= S_RESULT;
                S_RESULT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |->
            ((CW+1)'(fill_addr_reg) + (CW+1)'(fill_left_reg) <= (CW+1)'(DEPTH)))
        else $error("fill run crosses the end of the map");

    a_found_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DECIDE) && found_reg) |-> (LW'(best_len_reg) >= len_reg))
        else $error("chosen run shorter than request");

    a_clear_writes_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && ((state_reg == S_CSCAN) || (state_reg == S_CWAIT))) |->
            (mem_wdata == '0))
        else $error("clear pass wrote a nonzero tag");

    a_fill_owner_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_FILL) |-> (owner_reg != '0) && (op_reg == OP_ALLOC))
        else $error("fill started for owner zero or a clear");
`endif

endmodule

/* hdl/contiguous_fit_allocator_top.sv */
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_top: contiguous run allocator over an owner map
// Requests are served one at a time; the next is taken only after the engine
// has handed the last result to the output register and returned to idle.
// Reset: synchronous, active low; afterwards every cell of the map is swept
// to zero with s_ready low; fit_policy resets to best fit.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator_top
    import cfa_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int OWNER_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write channel: fit policy
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_data,
    // request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  in_beat_t   s_data,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output out_beat_t  m_data
);

    logic [1:0] fit_policy_reg;
    logic       m_valid_reg;
    out_beat_t  m_data_reg;

    logic       res_valid;
    logic       res_ready;
    out_beat_t  res_beat;

    // Configuration is to be changed only while idle; the block does not enforce this and accepts every beat.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_policy_reg <= FIT_POLICY_RST;
        end else if (cfg_valid) begin
            fit_policy_reg <= cfg_data;
        end
    end

    // The engine owns the map and its sequencing; it takes a new request
    // as soon as it has handed its result to the output register below.
    cfa_engine #(
        .DEPTH      (DEPTH),
        .OWNER_BITS (OWNER_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fit_policy (fit_policy_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_beat    (s_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_beat   (res_beat)
    );

    // Output register: hold the result beat until the sink takes it, and
    // load the next one in the same cycle that the current one leaves.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_data_reg <= res_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result beat dropped or changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status == ST_ALLOC) || (m_data.status == ST_NOFIT) ||
                     (m_data.status == ST_CLEAR)))
        else $error("illegal status code");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status != ST_ALLOC)) |-> (m_data.start_index == '0))
        else $error("start index nonzero without allocation");
`endif

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the contiguous fit allocator
// Drives allocate and clear beats under every placement policy and checks
// each result beat against an in-bench model of the owner map. Both sides
// stall at random, and the policy register changes only while the block is
// drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import cfa_pkg::*;

    localparam int DEPTH          = 1024;
    localparam int OWNER_BITS     = 16;
    // Slowest beat: a full-map scan plus the longest run write, with receiver
    // stalls on top. The sweep after reset is shorter.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES    = 32;

    // Policy codes not named by the package; both select first fit.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_SPARE = 2'd3;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_data = 2'd0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_beat_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_beat_t m_data;

    // Model state: owner map, active policy, results still owed.
    logic [OWNER_ID_W-1:0] owner_map [DEPTH];
    logic [1:0]            fit_sel;
    out_beat_t             owed_results [$];
    logic [OWNER_ID_W-1:0] live_owners [$];

    int unsigned beats_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned stalled_count = 0;
    bit          quiet         = 1'b0;

    contiguous_fit_allocator_top #(
        .DEPTH      (DEPTH),
        .OWNER_BITS (OWNER_BITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Receiver: stall with a chance of about 6 in a hundred unless in a quiet stretch.
    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 6);
    end

    // Apply one request beat to the model map and return the result it owes.
    function automatic out_beat_t place_or_free(input in_beat_t req);
        out_beat_t             res;
        logic [OWNER_ID_W-1:0] who;
        int unsigned           len, run_at, run_len, pick_at, pick_len, i;
        bit                    found, take, stop;
        res      = '0;
        who      = req.owner_id;
        len      = 32'(req.run_length);
        run_at   = 0;
        run_len  = 0;
        pick_at  = 0;
        pick_len = 0;
        found    = 1'b0;
        stop     = 1'b0;
        if (req.opcode == OP_CLEAR) begin
            // Owner zero marks free cells; clearing it changes nothing.
            if (who != '0) begin
                for (i = 0; i < DEPTH; i++)
                    if (owner_map[i] == who) owner_map[i] = '0;
            end
            res.status = ST_CLEAR;
            return res;
        end
        res.status = ST_NOFIT;
        if (who == '0 || len == 0 || len > DEPTH) return res;
        // Walk one past the end so the last free run is closed too.
        for (i = 0; i <= DEPTH && !stop; i++) begin
            if (i < DEPTH && owner_map[i] == '0) begin
                if (run_len == 0) run_at = i;
                run_len++;
            end else begin
                if (run_len >= len) begin
                    case (fit_sel)
                        POL_BEST:  take = !found || run_len < pick_len;
                        POL_WORST: take = !found || run_len > pick_len;
                        default:   take = !found;
                    endcase
                    if (take) begin
                        pick_at  = run_at;
                        pick_len = run_len;
                        found    = 1'b1;
                        // First fit stops at the lowest run that fits.
                        if (fit_sel != POL_BEST && fit_sel != POL_WORST) stop = 1'b1;
                    end
                end
                run_len = 0;
            end
        end
        if (!found) return res;
        for (i = 0; i < len; i++) owner_map[pick_at + i] = who;
        res.status      = ST_ALLOC;
        res.start_index = pick_at[START_IDX_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Scoreboard: check result beats in order, track policy writes, and
    // predict every accepted request beat.
    always @(posedge aclk) begin
        out_beat_t want;
        int        k;
        if (!aresetn) begin
            for (k = 0; k < DEPTH; k++) owner_map[k] = '0;
            fit_sel = FIT_POLICY_RST;
            owed_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (owed_results.size() == 0) begin
                    flag_mismatch("unexpected result status", 32'(m_data.status), 0);
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.status != want.status)
                        flag_mismatch("status", 32'(m_data.status), 32'(want.status));
                    if (m_data.start_index != want.start_index)
                        flag_mismatch("start_index", 32'(m_data.start_index),
                                      32'(want.start_index));
                end
            end
            if (cfg_valid && cfg_ready) fit_sel = cfg_data;
            if (s_valid && s_ready) owed_results.push_back(place_or_free(s_data));
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            stalled_count <= 0;
        end else begin
            stalled_count <= stalled_count + 1;
            if (stalled_count == WATCHDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Send one request beat. Valid is left high after acceptance; the next
    // call replaces the payload, an idle gap or drain_results drops it.
    task automatic send_req(input logic op, input logic [OWNER_ID_W-1:0] who,
                            input logic [RUN_LEN_W-1:0] len);
        in_beat_t req;
        req.opcode     = op;
        req.owner_id   = who;
        req.run_length = len;
        while (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    // Hold the sender until every owed result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_seen != beats_sent);
    endtask

    // Write the policy register; call only after drain_results.
    task automatic write_policy(input logic [1:0] pol);
        cfg_valid <= 1'b1;
        cfg_data  <= pol;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random request: mostly allocations and clears of live owners, some noise.
    task automatic send_random_req();
        int unsigned           pick, slot;
        logic [OWNER_ID_W-1:0] who;
        pick = $urandom_range(99);
        who  = OWNER_ID_W'($urandom_range(16'hFFFF, 1));
        if (pick < 60) begin
            live_owners.push_back(who);
            if ($urandom_range(19) == 0)
                send_req(OP_ALLOC, who, RUN_LEN_W'($urandom_range(DEPTH, 65)));
            else
                send_req(OP_ALLOC, who, RUN_LEN_W'($urandom_range(48, 1)));
        end else if (pick < 88 && live_owners.size() != 0) begin
            slot = $urandom_range(live_owners.size() - 1);
            who  = live_owners[slot];
            live_owners.delete(slot);
            send_req(OP_CLEAR, who, RUN_LEN_W'($urandom));
        end else begin
            case ($urandom_range(3))
                0: send_req(OP_ALLOC, '0, RUN_LEN_W'($urandom_range(DEPTH, 1)));
                1: send_req(OP_ALLOC, who, '0);
                2: send_req(OP_ALLOC, who, RUN_LEN_W'($urandom_range(2047, DEPTH + 1)));
                default: send_req(OP_CLEAR, $urandom_range(1) ? who : '0,
                                  RUN_LEN_W'($urandom));
            endcase
        end
    endtask

    // Random phase under one policy; pause halfway until drained.
    task automatic run_random_phase(input logic [1:0] pol, input int unsigned count);
        int unsigned n;
        drain_results();
        write_policy(pol);
        for (n = 0; n < count; n++) begin
            if (n == count / 2) drain_results();
            send_random_req();
        end
    endtask

    // Reset policy (best fit), full-map run, and every reject case.
    task automatic test_reset_state();
        send_req(OP_ALLOC, 16'hFFFF, RUN_LEN_W'(DEPTH));
        send_req(OP_ALLOC, 16'h0001, 11'd1);
        send_req(OP_CLEAR, 16'hFFFF, 11'd0);
        send_req(OP_ALLOC, 16'h0000, 11'd10);
        send_req(OP_CLEAR, 16'h0000, 11'h7FF);
        send_req(OP_ALLOC, 16'h0001, 11'd0);
        send_req(OP_ALLOC, 16'h0001, RUN_LEN_W'(DEPTH + 1));
        send_req(OP_ALLOC, 16'h8000, 11'h7FF);
    endtask

    // Carve holes of 50, 50 and 624 cells, then place under each policy:
    // tie to the lowest run, exact fit, largest run, spare code as first fit.
    task automatic test_fit_choice();
        drain_results();
        write_policy(POL_FIRST);
        send_req(OP_ALLOC, 16'd1, 11'd100);
        send_req(OP_ALLOC, 16'd2, 11'd50);
        send_req(OP_ALLOC, 16'd3, 11'd100);
        send_req(OP_ALLOC, 16'd4, 11'd50);
        send_req(OP_ALLOC, 16'd5, 11'd100);
        send_req(OP_CLEAR, 16'd2, 11'd0);
        send_req(OP_CLEAR, 16'd4, 11'd0);
        send_req(OP_ALLOC, 16'd6, 11'd700);
        drain_results();
        write_policy(POL_BEST);
        send_req(OP_ALLOC, 16'd7, 11'd40);
        send_req(OP_ALLOC, 16'd8, 11'd50);
        drain_results();
        write_policy(POL_WORST);
        send_req(OP_ALLOC, 16'd9, 11'd40);
        drain_results();
        write_policy(POL_SPARE);
        send_req(OP_ALLOC, 16'd10, 11'd5);
        send_req(OP_ALLOC, 16'd11, 11'd600);
    endtask

    task automatic test_first_fit_random();
        run_random_phase(POL_FIRST, 70);
    endtask

    // Run this phase without idling on either side.
    task automatic test_best_fit_random();
        quiet = 1'b1;
        run_random_phase(POL_BEST, 70);
        quiet = 1'b0;
    endtask

    task automatic test_worst_fit_random();
        run_random_phase(POL_WORST, 70);
    endtask

    task automatic test_spare_code_random();
        run_random_phase(POL_SPARE, 60);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_fit_choice();
        test_first_fit_random();
        test_best_fit_random();
        test_worst_fit_random();
        test_spare_code_random();
        drain_results();
        // Let any stray beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
